[sv/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("check failed");
`endif

[sv/jpid_pkg.sv]
`timescale 1ns / 1ps
package jpid_pkg;
    localparam int NUM_JOINTS = 32;
    localparam int JW = 5;
    localparam int QDEPTH = 2;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_RATE   = 1'b1;
    localparam logic [16:0] PERIOD_RESET = 17'd66;
    localparam logic [15:0] RATE_RESET   = 16'd1000;

    typedef struct packed {
        logic              cmd;
        logic [4:0]        joint_index;
        logic signed [31:0] position_value;
        logic signed [31:0] velocity_value;
        logic signed [31:0] feedforward_effort;
        logic signed [31:0] position_gain;
        logic signed [31:0] integral_gain;
        logic signed [31:0] derivative_gain;
        logic signed [31:0] velocity_gain;
        logic signed [31:0] integral_low;
        logic signed [31:0] integral_high;
    } in_item_t;

    typedef struct packed {
        logic [4:0]         joint_number;
        logic signed [31:0] drive_force;
    } out_item_t;

    typedef struct packed {
        logic [JW-1:0]      joint;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } tick_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_DER, ST_INT, ST_CLAMP,
        ST_P, ST_V, ST_I, ST_D, ST_SUM, ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) return 32'sh7fffffff;
        if (v < -65'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

[sv/jpid_front.sv]
`timescale 1ns / 1ps
module jpid_front import jpid_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     busy,
    output logic     st_we,
    output logic [JW-1:0] st_joint,
    output logic     q_valid,
    input  logic     q_ready,
    output tick_t    q_data
);
    tick_t q_reg [QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic acc, in_range, push, pop;

    assign in_range = 32'(s_data.joint_index) < NUM_JOINTS;
    // a store waits until no tick is queued or running
    assign s_ready  = cnt_reg != 2'(QDEPTH) &&
                      !(s_data.cmd == CMD_STORE && (q_valid || busy));
    assign acc      = s_valid && s_ready;
    assign push     = acc && in_range && s_data.cmd == CMD_TICK;
    assign st_we    = acc && in_range && s_data.cmd == CMD_STORE;
    assign st_joint = s_data.joint_index[JW-1:0];
    assign pop      = q_valid && q_ready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_data   = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= '{joint: s_data.joint_index[JW-1:0],
                               pos: s_data.position_value, vel: s_data.velocity_value};
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[sv/jpid_back.sv]
`timescale 1ns / 1ps
module jpid_back import jpid_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      st_we,
    input  logic [JW-1:0] st_joint,
    input  in_item_t  st_data,
    input  logic [16:0] period,
    input  logic [15:0] rate,
    input  logic      q_valid,
    output logic      q_ready,
    input  tick_t     q_data,
    output logic      busy,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    // per-joint state; small enough for flops with valid bits
    logic [NUM_JOINTS-1:0] tv_reg, sv_reg;
    logic signed [31:0] tp_reg [NUM_JOINTS], tvl_reg [NUM_JOINTS], ff_reg [NUM_JOINTS];
    logic signed [31:0] kp_reg [NUM_JOINTS], ki_reg [NUM_JOINTS];
    logic signed [31:0] kd_reg [NUM_JOINTS], kv_reg [NUM_JOINTS];
    logic signed [31:0] lo_reg [NUM_JOINTS], hi_reg [NUM_JOINTS];
    logic signed [31:0] pe_reg [NUM_JOINTS], ei_reg [NUM_JOINTS];

    state_t state_reg, state_next;
    tick_t cur_reg;
    logic signed [31:0] err_reg, verr_reg, der_reg, integ_reg;
    logic signed [63:0] prod_reg;
    logic signed [33:0] ma_reg;
    logic signed [33:0] mb_reg;
    logic signed [49:0] acc_reg;
    logic signed [31:0] out_reg;
    logic ov_reg;

    logic t_ok, s_ok;
    logic signed [31:0] tp, tvl, ff, kp, ki, kd, kv, lo, hi, pe, ei;
    logic signed [67:0] mult;
    logic signed [47:0] fq;
    logic signed [35:0] isum;

    assign t_ok = tv_reg[cur_reg.joint];
    assign s_ok = sv_reg[cur_reg.joint];
    assign tp  = t_ok ? tp_reg[cur_reg.joint]  : '0;
    assign tvl = t_ok ? tvl_reg[cur_reg.joint] : '0;
    assign ff  = t_ok ? ff_reg[cur_reg.joint]  : '0;
    assign kp  = t_ok ? kp_reg[cur_reg.joint]  : '0;
    assign ki  = t_ok ? ki_reg[cur_reg.joint]  : '0;
    assign kd  = t_ok ? kd_reg[cur_reg.joint]  : '0;
    assign kv  = t_ok ? kv_reg[cur_reg.joint]  : '0;
    assign lo  = t_ok ? lo_reg[cur_reg.joint]  : '0;
    assign hi  = t_ok ? hi_reg[cur_reg.joint]  : '0;
    assign pe  = s_ok ? pe_reg[cur_reg.joint]  : '0;
    assign ei  = s_ok ? ei_reg[cur_reg.joint]  : '0;

    assign mult = ma_reg * mb_reg;
    assign fq   = prod_reg[63:16];
    assign isum = 36'(ei) + 36'(fq);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid && !ov_reg) state_next = ST_ERR;
            ST_ERR:   state_next = ST_DER;
            ST_DER:   state_next = ST_INT;
            ST_INT:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_P;
            ST_P:     state_next = ST_V;
            ST_V:     state_next = ST_I;
            ST_I:     state_next = ST_D;
            ST_D:     state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready = state_reg == ST_IDLE && !ov_reg;
    end

    assign busy    = state_reg != ST_IDLE;
    assign m_valid = ov_reg;
    assign m_data  = '{joint_number: 5'(cur_reg.joint), drive_force: out_reg};

    always_ff @(posedge aclk) begin
        if (st_we) begin
            tp_reg[st_joint]  <= st_data.position_value;
            tvl_reg[st_joint] <= st_data.velocity_value;
            ff_reg[st_joint]  <= st_data.feedforward_effort;
            kp_reg[st_joint]  <= st_data.position_gain;
            ki_reg[st_joint]  <= st_data.integral_gain;
            kd_reg[st_joint]  <= st_data.derivative_gain;
            kv_reg[st_joint]  <= st_data.velocity_gain;
            lo_reg[st_joint]  <= st_data.integral_low;
            hi_reg[st_joint]  <= st_data.integral_high;
        end
        prod_reg <= mult[63:0];
        case (state_reg)
            ST_IDLE: if (q_valid && q_ready) cur_reg <= q_data;
            ST_ERR: begin
                err_reg  <= sat32(65'(tp) - 65'(cur_reg.pos));
                verr_reg <= sat32(65'(tvl) - 65'(cur_reg.vel));
                ma_reg   <= 34'(65'(tp) - 65'(cur_reg.pos));
                mb_reg   <= '0;
            end
            ST_DER: begin
                ma_reg <= 34'(err_reg) - 34'(pe);
                mb_reg <= 34'(rate);
            end
            ST_INT: begin
                ma_reg <= 34'(err_reg);
                mb_reg <= 34'(period);
            end
            ST_CLAMP: begin
                der_reg <= sat32(65'(prod_reg));
                ma_reg  <= 34'(kp);
                mb_reg  <= 34'(err_reg);
            end
            ST_P: begin
                integ_reg <= (isum > 36'(hi)) ? ((hi < lo) ? lo : hi) :
                             ((isum < 36'(lo)) ? lo : isum[31:0]);
                acc_reg   <= 50'(ff);
                ma_reg    <= 34'(kv);
                mb_reg    <= 34'(verr_reg);
            end
            ST_V: begin
                acc_reg <= acc_reg + 50'(fq);
                ma_reg  <= 34'(ki);
                mb_reg  <= 34'(integ_reg);
            end
            ST_I: begin
                acc_reg <= acc_reg + 50'(fq);
                ma_reg  <= 34'(kd);
                mb_reg  <= 34'(der_reg);
            end
            ST_D:   acc_reg <= acc_reg + 50'(fq);
            ST_SUM: acc_reg <= acc_reg + 50'(fq);
            ST_OUT: begin
                out_reg <= sat32(65'(acc_reg));
                pe_reg[cur_reg.joint] <= err_reg;
                ei_reg[cur_reg.joint] <= integ_reg;
            end
            default: ;
        endcase
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            tv_reg <= '0;
            sv_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (st_we) tv_reg[st_joint] <= 1'b1;
            if (state_reg == ST_OUT) begin
                sv_reg[cur_reg.joint] <= 1'b1;
                ov_reg <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

[sv/joint_pid_with_feedforward.sv]
`timescale 1ns / 1ps
// Multi-joint PID with feedforward, Q16.16 data.
// Input channel s_valid/s_ready/s_data: cmd 0 stores a joint's targets,
// gains and integral limits; cmd 1 runs a control tick for that joint.
// Stores take effect in the cycle of acceptance and give no result; a store
// waits until no tick is queued or running.
// Each tick gives one m_data result (joint number and drive force).
// Config port cfg_we/cfg_index/cfg_data: 0 period, 1 rate; write when idle.
// Ticks queue in a two-entry FIFO; the back end runs one tick at a time
// through a single shared multiplier and takes the next tick only once it is
// idle and its last result has been taken; m_valid is registered in ST_OUT.
// When the result is not taken, the result register holds it and the
// back end waits; the FIFO keeps accepting until full.
// Reset (synchronous, aresetn low) clears all joint tables to zero via
// valid bits and restores period 66 and rate 1000; no clearing pass.
module joint_pid_with_feedforward import jpid_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [16:0] cfg_data
);
    logic [16:0] period_reg;
    logic [15:0] rate_reg;
    logic st_we, q_valid, q_ready, back_busy;
    logic [JW-1:0] st_joint;
    tick_t q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            rate_reg   <= RATE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_data;
                CFG_RATE:   rate_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    jpid_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .busy(back_busy),
        .st_we, .st_joint, .q_valid, .q_ready, .q_data
    );

    jpid_back u_back (
        .aclk, .aresetn, .st_we, .st_joint, .st_data(s_data),
        .period(period_reg), .rate(rate_reg),
        .q_valid, .q_ready, .q_data, .busy(back_busy),
        .m_valid, .m_ready, .m_data
    );
endmodule

[sv/jpid_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jpid_checker import jpid_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);
    `CHK_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `CHK_IMPLY(a_m_range, aclk, aresetn, m_valid, 32'(m_data.joint_number) < NUM_JOINTS)
    `CHK_NEXT(a_m_gap, aclk, aresetn, m_valid && m_ready, !m_valid)
endmodule

bind joint_pid_with_feedforward jpid_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);

[bench/joint_pid_with_feedforward_test.sv]
`timescale 1ns / 1ps
module joint_pid_with_feedforward_test;
    import jpid_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_PERIOD;
    logic [16:0] cfg_data = '0;

    joint_pid_with_feedforward uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // controller copy
    logic [16:0]        pid_period;
    logic [15:0]        pid_rate;
    logic signed [31:0] tgt_pos [NUM_JOINTS];
    logic signed [31:0] tgt_vel [NUM_JOINTS];
    logic signed [31:0] tgt_ff  [NUM_JOINTS];
    logic signed [31:0] kp [NUM_JOINTS];
    logic signed [31:0] ki [NUM_JOINTS];
    logic signed [31:0] kd [NUM_JOINTS];
    logic signed [31:0] kv [NUM_JOINTS];
    logic signed [31:0] int_lo [NUM_JOINTS];
    logic signed [31:0] int_hi [NUM_JOINTS];
    logic signed [31:0] last_err [NUM_JOINTS];
    logic signed [31:0] err_sum [NUM_JOINTS];

    out_item_t   force_queue[$];
    int unsigned mismatches = 0;
    int unsigned forces_seen = 0;
    int unsigned requests_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap_max = 3;
    int unsigned recv_gap_max = 3;

    function automatic logic signed [31:0] clip32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'sh7fffffff;
        if (v < -96'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [95:0] q16_floor(input logic signed [95:0] v);
        return v >>> 16;
    endfunction

    task automatic predict_force(input in_item_t it);
        int j;
        logic signed [95:0] e, ve, dv, ig, acc;
        out_item_t res;
        j = it.joint_index;
        if (it.cmd == CMD_STORE) begin
            tgt_pos[j] = it.position_value;
            tgt_vel[j] = it.velocity_value;
            tgt_ff[j] = it.feedforward_effort;
            kp[j] = it.position_gain;
            ki[j] = it.integral_gain;
            kd[j] = it.derivative_gain;
            kv[j] = it.velocity_gain;
            int_lo[j] = it.integral_low;
            int_hi[j] = it.integral_high;
            return;
        end
        e = clip32(96'(tgt_pos[j]) - 96'(it.position_value));
        ve = clip32(96'(tgt_vel[j]) - 96'(it.velocity_value));
        dv = clip32((e - 96'(last_err[j])) * $signed({1'b0, pid_rate}));
        last_err[j] = e[31:0];
        ig = 96'(err_sum[j]) + q16_floor($signed({1'b0, pid_period}) * e);
        if (ig > 96'(int_hi[j])) ig = 96'(int_hi[j]);
        if (ig < 96'(int_lo[j])) ig = 96'(int_lo[j]);
        err_sum[j] = ig[31:0];
        acc = q16_floor(96'(kp[j]) * e) + q16_floor(96'(kv[j]) * ve)
            + q16_floor(96'(ki[j]) * ig) + q16_floor(96'(kd[j]) * dv)
            + 96'(tgt_ff[j]);
        res.joint_number = it.joint_index;
        res.drive_force = clip32(acc);
        force_queue.insert(force_queue.size(), res);
    endtask

    function automatic int unsigned pick_gap(input int unsigned gmax);
        if (gmax == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, gmax);
    endfunction

    task automatic send_request(input in_item_t it);
        int unsigned gap;
        gap = pick_gap(send_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_force(it);
        requests_sent++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (force_queue.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_PERIOD) pid_period = val;
        else pid_rate = val[15:0];
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) - 4;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(0, 7) == 0) return rand_word();
        return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
    endfunction

    function automatic in_item_t rand_store(input logic [4:0] j);
        in_item_t it;
        it = '0;
        it.cmd = CMD_STORE;
        it.joint_index = j;
        it.position_value = rand_word();
        it.velocity_value = rand_word();
        it.feedforward_effort = rand_word();
        it.position_gain = rand_gain();
        it.integral_gain = rand_gain();
        it.derivative_gain = rand_gain();
        it.velocity_gain = rand_gain();
        it.integral_low = rand_word();
        it.integral_high = rand_word();
        if ($urandom_range(0, 3) != 0 && it.integral_low > it.integral_high) begin
            it.integral_low = it.integral_high;
            it.integral_high = rand_word();
            if (it.integral_low > it.integral_high) it.integral_high = 32'h7fffffff;
        end
        return it;
    endfunction

    function automatic in_item_t rand_tick(input logic [4:0] j);
        in_item_t it;
        it = '0;
        it.feedforward_effort = $urandom;
        it.position_gain = $urandom;
        it.integral_gain = $urandom;
        it.derivative_gain = $urandom;
        it.velocity_gain = $urandom;
        it.integral_low = $urandom;
        it.integral_high = $urandom;
        it.cmd = CMD_TICK;
        it.joint_index = j;
        it.position_value = rand_word();
        it.velocity_value = rand_word();
        return it;
    endfunction

    task automatic test_directed;
        in_item_t it;
        // first tick on untouched joint, then extremes
        send_request(rand_tick(5'd0));
        it = '0;
        it.cmd = CMD_STORE;
        it.joint_index = 5'd31;
        it.position_value = 32'sh7fffffff;
        it.velocity_value = 32'sh80000000;
        it.feedforward_effort = 32'sh7fffffff;
        it.position_gain = 32'sh7fffffff;
        it.integral_gain = 32'sh80000000;
        it.derivative_gain = 32'sh7fffffff;
        it.velocity_gain = 32'sh80000000;
        it.integral_low = 32'sh80000000;
        it.integral_high = 32'sh7fffffff;
        send_request(it);
        it.cmd = CMD_TICK;
        it.position_value = 32'sh80000000;
        it.velocity_value = 32'sh7fffffff;
        send_request(it);
        send_request(it);
        it.position_value = 32'sh7fffffff;
        it.velocity_value = 32'sh80000000;
        send_request(it);
        // crossed limits
        it = '0;
        it.cmd = CMD_STORE;
        it.joint_index = 5'd7;
        it.position_value = 32'sh00010000;
        it.position_gain = 32'sh00010000;
        it.integral_gain = 32'sh00020000;
        it.derivative_gain = 32'shffff0000;
        it.velocity_gain = 32'sh00008000;
        it.integral_low = 32'sh00050000;
        it.integral_high = 32'shfffb0000;
        send_request(it);
        it.cmd = CMD_TICK;
        it.position_value = 32'shfff00000;
        send_request(it);
        send_request(it);
        drain();
        write_reg(CFG_PERIOD, 17'd0);
        write_reg(CFG_RATE, 17'd0);
        send_request(it);
        send_request(rand_tick(5'd31));
        drain();
        write_reg(CFG_PERIOD, 17'h10000);
        write_reg(CFG_RATE, 17'hffff);
        send_request(it);
        send_request(rand_tick(5'd31));
        drain();
    endtask

    task automatic test_random_mix(input int unsigned count);
        logic [4:0] j;
        for (int unsigned n = 0; n < count; n++) begin
            j = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0) send_request(rand_store(j));
            else send_request(rand_tick(j));
        end
    endtask

    task automatic test_config_sweep;
        logic [16:0] periods [4] = '{17'd1, 17'd66, 17'h10000, 17'h1ffff};
        logic [15:0] rates [4] = '{16'd1, 16'd1000, 16'hffff, 16'd0};
        for (int k = 0; k < 4; k++) begin
            drain();
            write_reg(CFG_PERIOD, periods[k]);
            write_reg(CFG_RATE, {1'b0, rates[k]});
            test_random_mix(200);
        end
        drain();
        write_reg(CFG_PERIOD, 17'($urandom));
        write_reg(CFG_RATE, {1'b0, 16'($urandom)});
        test_random_mix(150);
    endtask

    task automatic test_backpressure;
        send_gap_max = 0;
        recv_gap_max = 12;
        test_random_mix(250);
        // hold-off until everything is out
        s_valid <= 1'b0;
        while (force_queue.size() != 0) @(posedge aclk);
        send_gap_max = 6;
        recv_gap_max = 0;
        test_random_mix(250);
        recv_gap_max = 3;
        send_gap_max = 3;
        test_random_mix(200);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            forces_seen++;
            if (force_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected force: joint %0d force %0d",
                             m_data.joint_number, m_data.drive_force);
            end else begin
                want = force_queue.pop_front();
                if (want !== m_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp joint %0d force %0d, got joint %0d force %0d",
                                 want.joint_number, want.drive_force,
                                 m_data.joint_number, m_data.drive_force);
                end
            end
        end
    end

    initial begin
        int unsigned gap;
        forever begin
            @(posedge aclk);
            gap = (recv_gap_max == 0 || $urandom_range(0, 2) != 0) ? 0 :
                  pick_gap(recv_gap_max);
            if (gap == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("timeout");
            $display("joint_pid_with_feedforward_test failed");
            $finish;
        end
    end

    initial begin
        pid_period = PERIOD_RESET;
        pid_rate = RATE_RESET;
        for (int k = 0; k < NUM_JOINTS; k++) begin
            tgt_pos[k] = '0; tgt_vel[k] = '0; tgt_ff[k] = '0;
            kp[k] = '0; ki[k] = '0; kd[k] = '0; kv[k] = '0;
            int_lo[k] = '0; int_hi[k] = '0; last_err[k] = '0; err_sum[k] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        drain();
        $display("sent %0d requests, checked %0d drive forces, %0d mismatches",
                 requests_sent, forces_seen, mismatches);
        $display("covered stores, ticks, extremes, crossed limits, zero and max period/rate");
        if (mismatches == 0 && force_queue.size() == 0) begin
            $display("joint_pid_with_feedforward_test passed");
        end else begin
            $display("joint_pid_with_feedforward_test failed");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/jpid_pkg.sv
sv/jpid_front.sv
sv/jpid_back.sv
sv/joint_pid_with_feedforward.sv
sv/jpid_checker.sv
bench/joint_pid_with_feedforward_test.sv
